// ----- rtl/core/aes_pkg.sv -----
// Package for the AES block cipher: S-box tables, round-step functions and FSM type.
// Used by aes_block_cipher; depends on nothing else.
package aes_pkg;

   localparam int RoundKeyWordsDefault = 60;

   typedef logic [7:0] byte_table_type [256];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_LOAD,
      ST_INIT,
      ST_ROUND,
      ST_DONE
   } aes_state_type;

   // Key size codes.
   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;
   localparam logic [1:0] KEY_256 = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [2:0] CSR_KEY_A    = 3'd1;
   localparam logic [2:0] CSR_KEY_B    = 3'd2;
   localparam logic [2:0] CSR_KEY_C    = 3'd3;
   localparam logic [2:0] CSR_KEY_D    = 3'd4;

   localparam logic [7:0] GF_POLY = 8'h1B;
   localparam logic [7:0] AFFINE_C = 8'h63;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = a[7] ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      gf_mul = p;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int s);
      rotl8 = (v << s) | (v >> (8 - s));
   endfunction

   // Forward S-box, built at elaboration: field inverse (a^254) then the affine map.
   function automatic byte_table_type gen_sbox();
      byte_table_type t;
      logic [7:0] r;
      logic [7:0] base;
      logic [7:0] e;
      for (int a = 0; a < 256; a++) begin
         r = 8'h01;
         base = 8'(a);
         e = 8'd254;
         for (int k = 0; k < 8; k++) begin
            if (e[k]) r = gf_mul(r, base);
            base = gf_mul(base, base);
         end
         t[a] = r ^ rotl8(r, 1) ^ rotl8(r, 2) ^ rotl8(r, 3) ^ rotl8(r, 4) ^ AFFINE_C;
      end
      gen_sbox = t;
   endfunction

   localparam byte_table_type SBOX = gen_sbox();

   function automatic byte_table_type gen_inv_sbox();
      byte_table_type t;
      for (int a = 0; a < 256; a++) begin
         t[SBOX[a]] = 8'(a);
      end
      gen_inv_sbox = t;
   endfunction

   localparam byte_table_type INV_SBOX = gen_inv_sbox();

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // State byte i sits at bits [127-8i -: 8]; column c holds bytes 4c..4c+3.
   function automatic logic [127:0] sbox_state(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      for (int i = 0; i < 16; i++) begin
         o[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
      end
      sbox_state = o;
   endfunction

   function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      int src;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? (r + 4 * ((c + 4 - r) % 4)) : (r + 4 * ((c + r) % 4));
            o[127-8*(r+4*c) -: 8] = s[127-8*src -: 8];
         end
      end
      row_shift = o;
   endfunction

   function automatic logic [127:0] column_mix(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      logic [7:0] m [4];
      logic [7:0] acc;
      if (inv) begin
         m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
      end else begin
         m[0] = 8'd2;  m[1] = 8'd3;  m[2] = 8'd1;  m[3] = 8'd1;
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) begin
               acc = acc ^ gf_mul(s[127-8*(k+4*c) -: 8], m[(k + 4 - r) % 4]);
            end
            o[127-8*(r+4*c) -: 8] = acc;
         end
      end
      column_mix = o;
   endfunction

endpackage

// ----- rtl/core/aes_block_cipher.sv -----
// AES-128/192/256 block cipher with an on-chip round-key store and one shared round unit.
// Depends on aes_pkg for the S-box tables, round functions and state type.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_tvalid/tready  | tdata = block_high, block_low; tuser = kind
//   rsp     | out       | rsp_tvalid/tready  | tdata = result_high, result_low; tuser = status
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// A block passes the load, init, round and done states before a valid response; it takes nr
// rounds (nr = 10, 12 or 14) on the single round unit that does one AES round per cycle.
// The first block after reset or after a register write first expands the key,
// one round-key word per cycle: 44, 52 or 60 words.
// A bad key size goes straight to the done state and answers with status set and a zero block.
// Reset is synchronous; the key store holds no reset value. A stalled response
// holds the block in its final state until the output register frees up.
module aes_block_cipher
   import aes_pkg::*;
#(
   parameter int ROUND_KEY_WORDS = RoundKeyWordsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] block_high, [127:64] block_low
   input  logic         req_tuser,   // [0] kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] result_high, [127:64] result_low
   output logic         rsp_tuser,   // [0] status
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int Rows = ROUND_KEY_WORDS / 4;
   localparam int RW   = $clog2(Rows + 1);
   localparam int IW   = $clog2(ROUND_KEY_WORDS + 1);

   // Configuration registers.
   logic [1:0]  key_size_ff;
   logic [63:0] key_a_ff, key_b_ff, key_c_ff, key_d_ff;
   logic        keys_ready_ff, keys_ready_in;
   logic        csr_hit;

   // Round-key store, one 128-bit row per round.
   logic [127:0] store_ff [Rows];
   logic [127:0] rk_ff;
   logic [RW-1:0] rd_row;

   // Sequencer state.
   aes_state_type state_ff, state_in;
   logic [127:0] blk_ff, blk_in;
   logic         dec_ff, dec_in;
   logic         bad_ff, bad_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [IW-1:0] wi_ff, wi_in;
   logic [2:0]   wj_ff, wj_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [31:0]  win_ff [8];
   logic         exp_we;
   logic [31:0]  exp_word;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff;
   logic         rsp_status_ff;
   logic         rsp_load;

   // Key geometry.
   logic [3:0] nk, nr;
   logic [5:0] total;
   logic       size_bad;

   always_comb begin
      unique case (key_size_ff)
         KEY_128: nk = 4'd4;
         KEY_192: nk = 4'd6;
         KEY_256: nk = 4'd8;
         default: nk = 4'd0;
      endcase
      nr = nk + 4'd6;
      total = {nr, 2'b00} + 6'd4;
      size_bad = (nk == 4'd0) || (32'(total) > ROUND_KEY_WORDS);
   end

   // Configuration writes; any write to a known register invalidates the key store.
   assign csr_ready = 1'b1;
   assign csr_hit = csr_valid && (csr_index == CSR_KEY_SIZE || csr_index == CSR_KEY_A ||
                                  csr_index == CSR_KEY_B || csr_index == CSR_KEY_C ||
                                  csr_index == CSR_KEY_D);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= KEY_128;
         key_a_ff    <= '0;
         key_b_ff    <= '0;
         key_c_ff    <= '0;
         key_d_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_SIZE: key_size_ff <= csr_data[1:0];
            CSR_KEY_A:    key_a_ff    <= csr_data;
            CSR_KEY_B:    key_b_ff    <= csr_data;
            CSR_KEY_C:    key_c_ff    <= csr_data;
            CSR_KEY_D:    key_d_ff    <= csr_data;
            default:      ;
         endcase
      end
   end

   // Key expansion: one new word per cycle from a window of the last eight words.
   logic [31:0] key_words [8];
   logic [31:0] prev_word, far_word, tmp_word;

   always_comb begin
      key_words[0] = key_a_ff[63:32]; key_words[1] = key_a_ff[31:0];
      key_words[2] = key_b_ff[63:32]; key_words[3] = key_b_ff[31:0];
      key_words[4] = key_c_ff[63:32]; key_words[5] = key_c_ff[31:0];
      key_words[6] = key_d_ff[63:32]; key_words[7] = key_d_ff[31:0];
      prev_word = win_ff[0];
      far_word  = win_ff[3'(nk - 4'd1)];
      if (wj_ff == 3'd0) begin
         tmp_word = sbox_word({prev_word[23:0], prev_word[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && wj_ff == 3'd4) begin
         tmp_word = sbox_word(prev_word);
      end else begin
         tmp_word = prev_word;
      end
      if (32'(wi_ff) < 32'(nk)) begin
         exp_word = key_words[wi_ff[2:0]];
      end else begin
         exp_word = far_word ^ tmp_word;
      end
   end

   always_ff @(posedge clock) begin
      if (exp_we) begin
         store_ff[RW'(wi_ff >> 2)][127 - 32 * wi_ff[1:0] -: 32] <= exp_word;
         win_ff[0] <= exp_word;
         for (int k = 1; k < 8; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
      rk_ff <= store_ff[rd_row];
   end

   // One AES round on the block register.
   logic         last_round;
   logic [127:0] enc_round, dec_round, dec_pre;

   always_comb begin
      last_round = (cnt_ff == nr);
      enc_round = row_shift(sbox_state(blk_ff, 1'b0), 1'b0);
      if (!last_round) enc_round = column_mix(enc_round, 1'b0);
      enc_round = enc_round ^ rk_ff;
      dec_pre   = sbox_state(row_shift(blk_ff, 1'b1), 1'b1) ^ rk_ff;
      dec_round = last_round ? dec_pre : column_mix(dec_pre, 1'b1);
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      state_in      = state_ff;
      blk_in        = blk_ff;
      dec_in        = dec_ff;
      bad_in        = bad_ff;
      cnt_in        = cnt_ff;
      wi_in         = wi_ff;
      wj_in         = wj_ff;
      rcon_in       = rcon_ff;
      keys_ready_in = keys_ready_ff;
      exp_we        = 1'b0;
      rsp_load      = 1'b0;
      rd_row        = '0;
      req_tready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               blk_in = {req_tdata[63:0], req_tdata[127:64]};
               dec_in = req_tuser;
               bad_in = size_bad;
               wi_in  = '0;
               wj_in  = '0;
               rcon_in = 8'h01;
               if (size_bad) begin
                  blk_in   = '0;
                  state_in = ST_DONE;
               end else if (!keys_ready_ff) begin
                  state_in = ST_EXPAND;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_EXPAND: begin
            exp_we = 1'b1;
            wi_in  = wi_ff + 1'b1;
            wj_in  = (4'(wj_ff) == nk - 4'd1) ? 3'd0 : wj_ff + 3'd1;
            if (wj_ff == 3'd0 && 32'(wi_ff) >= 32'(nk)) rcon_in = xtime(rcon_ff);
            if (32'(wi_ff) == 32'(total) - 1) begin
               keys_ready_in = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rd_row   = dec_ff ? RW'(nr) : '0;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            blk_in   = blk_ff ^ rk_ff;
            rd_row   = dec_ff ? RW'(nr - 4'd1) : RW'(1);
            cnt_in   = 4'd1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            blk_in = dec_ff ? dec_round : enc_round;
            cnt_in = cnt_ff + 4'd1;
            if (!last_round) begin
               rd_row = dec_ff ? RW'(nr - cnt_ff - 4'd1) : RW'(cnt_ff + 4'd1);
            end
            if (last_round) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_hit) keys_ready_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         keys_ready_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         keys_ready_ff <= keys_ready_in;
      end
      blk_ff  <= blk_in;
      dec_ff  <= dec_in;
      bad_ff  <= bad_in;
      cnt_ff  <= cnt_in;
      wi_ff   <= wi_in;
      wj_ff   <= wj_in;
      rcon_ff <= rcon_in;
   end

   // Output register; the sequencer waits in its final state while it is full.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_data_ff   <= {blk_ff[63:0], blk_ff[127:64]};
         rsp_status_ff <= bad_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- rtl/core/aes_checker.sv -----
// Port-level checker for aes_block_cipher, attached by the bind statement below.
// Depends on the top level's port list only.
module aes_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser
);

   // A stalled response keeps its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A bad key size always comes with a zero block.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("bad key size response carries data");

   // The block works on one request at a time.
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request accepted while busy");

   // No response is pending right after reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind aes_block_cipher aes_checker u_aes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
